// ----- rtl/ats_pkg.sv -----
package ats_pkg;

    localparam int MAX_TILES  = 64;
    localparam int MAX_MODES  = 16;
    localparam int TILE_W     = 6;
    localparam int MODE_W     = 4;
    localparam int COUNT_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int MC_W       = 5;
    localparam int ADDR_W     = TILE_W + MODE_W;
    localparam int STORE_DEPTH = MAX_TILES * MAX_MODES;
    localparam int TOTAL_W    = COUNT_W + MODE_W;        // sum of up to 16 counts
    localparam int PROD_W     = COUNT_W + MC_W;          // count * modes
    localparam int DIVIDEND_W = PROD_W + FRAC_W;
    localparam int WP_W       = FRAC_W + MODE_W + 1;     // up to modes * 1.0
    localparam int PROB_W     = FRAC_W + 1;              // Q1.16
    localparam int TBL_W      = PROB_W + MODE_W;         // {prob, alias}
    localparam int TIU_W      = 7;
    localparam int PADDR_W    = 3;

    localparam logic [WP_W-1:0]   ONE_FX   = WP_W'(1) << FRAC_W;
    localparam logic [PROB_W-1:0] ONE_PROB = PROB_W'(1) << FRAC_W;
    localparam logic [MC_W-1:0]   MC_MAX   = MC_W'(MAX_MODES);
    localparam logic [TIU_W-1:0]  TIU_MAX  = TIU_W'(MAX_TILES);
    localparam logic [TIU_W-1:0]  TIU_RESET = 7'd64;
    localparam logic [PADDR_W-1:0] ADDR_TILES_IN_USE = 3'd0;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_MODES  = 2'd1;
    localparam logic [1:0] FUNC_BUILD  = 2'd2;
    localparam logic [1:0] FUNC_SAMPLE = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SKIP  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [TILE_W-1:0]  tile;
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
        logic [MC_W-1:0]    mode_count;
        logic [FRAC_W-1:0]  rand_fraction;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0] chosen_mode;
        logic [1:0]        status;
    } result_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SMP_RD,
        ST_SMP_EV,
        ST_BLD_TILE,
        ST_BLD_N,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_P_RD,
        ST_P_DIV,
        ST_P_WAIT,
        ST_PAIR_S,
        ST_PAIR_L,
        ST_PAIR_WR,
        ST_LEFT_RD,
        ST_LEFT_WR,
        ST_FIN
    } state_t;

endpackage

// ----- rtl/alias_table_build_and_sample_top.sv -----
// Flow: a count or mode-count write goes from accept through ST_FIN to the result word;
//   a sample reads in ST_SMP_RD and decides in ST_SMP_EV. Per tile, a build
//   sums n counts, runs one 21-step divide per mode, pairs, writes leftovers; n = mode count.
// Throughput: one item at a time; the next item is taken once the result is queued.
// Reset: asynchronous, active low; then a clearing pass sweeps all 1024 count and table
//   entries and the 64 mode-count entries while item_stall stays high (config still taken).
module alias_table_build_and_sample_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  ats_pkg::item_t      item,
    output logic                result_valid,
    input  logic                result_stall,
    output ats_pkg::result_t    result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ats_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ats_pkg::*;

    state_t state_reg, state_next;

    // config
    logic [TIU_W-1:0]   tiles_in_use_reg;
    logic [TIU_W-1:0]   lim;
    logic               tiu_sel;

    // held item and result
    item_t              item_reg;
    logic [MODE_W-1:0]  res_chosen_reg, res_chosen_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;

    // build control
    logic [ADDR_W:0]    clr_reg, clr_next;
    logic [TIU_W-1:0]   cur_tile_reg, cur_tile_next;
    logic               skip_reg, skip_next;
    logic [MC_W-1:0]    n_reg, n_next;
    logic [MC_W-1:0]    j_reg, j_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [MC_W-1:0]    ns_reg, ns_next;
    logic [MC_W-1:0]    nl_reg, nl_next;
    logic [WP_W-1:0]    ps_reg, ps_next;
    logic [WP_W-1:0]    pl_reg, pl_next;

    // scratch for one tile
    logic [WP_W-1:0]    wp_reg [MAX_MODES];
    logic [MODE_W-1:0]  small_reg [MAX_MODES];
    logic [MODE_W-1:0]  large_reg [MAX_MODES];
    logic               wp_we;
    logic [MODE_W-1:0]  wp_widx, wp_ridx;
    logic [WP_W-1:0]    wp_wdata, wp_rd;
    logic               small_we, large_we;
    logic [MODE_W-1:0]  small_widx, large_widx, small_wdata, large_wdata;

    logic [MC_W-1:0]    ns_m1, nl_m1;
    logic [MODE_W-1:0]  s_top, l_top, left_idx;
    logic [WP_W:0]      pair_sum;
    logic [WP_W-1:0]    new_l;
    logic [TOTAL_W-1:0] sum_acc;
    logic [PROD_W-1:0]  prod;
    logic [MC_W-1:0]    mc_clamped;
    logic               accept, out_free;

    // memories
    logic               cnt_we, tbl_we, tmc_we;
    logic [ADDR_W-1:0]  cnt_waddr, cnt_raddr, tbl_waddr, tbl_raddr;
    logic [TILE_W-1:0]  tmc_waddr, tmc_raddr;
    logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
    logic [TBL_W-1:0]   tbl_wdata, tbl_rdata;
    logic [MC_W-1:0]    tmc_wdata, tmc_rdata;

    // divider
    logic               div_start, div_done;
    logic [WP_W-1:0]    div_q;

    ats_ram #(.WIDTH(COUNT_W), .DEPTH(STORE_DEPTH)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    // probability and alias share one word: {prob, alias}
    ats_ram #(.WIDTH(TBL_W), .DEPTH(STORE_DEPTH)) u_tbl (
        .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .raddr(tbl_raddr), .rdata(tbl_rdata)
    );

    ats_ram #(.WIDTH(MC_W), .DEPTH(MAX_TILES)) u_tmc (
        .clk(clk), .we(tmc_we), .waddr(tmc_waddr), .wdata(tmc_wdata),
        .raddr(tmc_raddr), .rdata(tmc_rdata)
    );

    ats_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend({prod, FRAC_W'(0)}), .divisor(total_reg),
        .done(div_done), .quotient(div_q)
    );

    // APB: single register, always ready; decode the word address only
    assign pready  = 1'b1;
    assign tiu_sel = (paddr[PADDR_W-1:2] == ADDR_TILES_IN_USE[PADDR_W-1:2]);
    assign prdata  = tiu_sel ? 32'(tiles_in_use_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiles_in_use_reg <= TIU_RESET;
        end
        else if (psel && penable && pwrite && pready && tiu_sel)
        begin
            tiles_in_use_reg <= pwdata[TIU_W-1:0];
        end
    end

    assign lim = (tiles_in_use_reg > TIU_MAX) ? TIU_MAX : tiles_in_use_reg;

    // accept only while idle; a finished word waits in the output register
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    assign ns_m1 = ns_reg - MC_W'(1);
    assign nl_m1 = nl_reg - MC_W'(1);
    assign s_top = small_reg[ns_m1[MODE_W-1:0]];
    assign l_top = large_reg[nl_m1[MODE_W-1:0]];
    assign left_idx = (nl_reg != '0) ? l_top : s_top;
    assign wp_rd = wp_reg[wp_ridx];
    assign pair_sum = {1'b0, pl_reg} + {1'b0, ps_reg};
    assign new_l = WP_W'(pair_sum - {1'b0, ONE_FX});
    assign sum_acc = total_reg + TOTAL_W'(cnt_rdata);
    assign prod = PROD_W'(cnt_rdata) * PROD_W'(n_reg);
    assign mc_clamped = (item.mode_count == '0) ? MC_W'(1) :
                        (item.mode_count > MC_MAX) ? MC_MAX : item.mode_count;

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        cur_tile_next     = cur_tile_reg;
        skip_next         = skip_reg;
        n_next            = n_reg;
        j_next            = j_reg;
        total_next        = total_reg;
        ns_next           = ns_reg;
        nl_next           = nl_reg;
        ps_next           = ps_reg;
        pl_next           = pl_reg;
        res_chosen_next   = res_chosen_reg;
        res_status_next   = res_status_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        cnt_we    = 1'b0;
        cnt_waddr = {item.tile, item.mode};
        cnt_wdata = item.count;
        cnt_raddr = {cur_tile_reg[TILE_W-1:0], j_reg[MODE_W-1:0]};
        tbl_we    = 1'b0;
        tbl_waddr = {cur_tile_reg[TILE_W-1:0], left_idx};
        tbl_wdata = {ONE_PROB, tbl_rdata[MODE_W-1:0]};
        tbl_raddr = {cur_tile_reg[TILE_W-1:0], left_idx};
        tmc_we    = 1'b0;
        tmc_waddr = item.tile;
        tmc_wdata = mc_clamped;
        tmc_raddr = cur_tile_reg[TILE_W-1:0];

        div_start   = 1'b0;
        wp_we       = 1'b0;
        wp_widx     = j_reg[MODE_W-1:0];
        wp_wdata    = div_q;
        wp_ridx     = s_top;
        small_we    = 1'b0;
        small_widx  = ns_reg[MODE_W-1:0];
        small_wdata = j_reg[MODE_W-1:0];
        large_we    = 1'b0;
        large_widx  = nl_reg[MODE_W-1:0];
        large_wdata = j_reg[MODE_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep every entry to its reset value
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg[ADDR_W-1:0];
                cnt_wdata = '0;
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg[ADDR_W-1:0];
                tbl_wdata = {ONE_PROB, MODE_W'(0)};
                tmc_we    = (clr_reg < (ADDR_W+1)'(MAX_TILES));
                tmc_waddr = clr_reg[TILE_W-1:0];
                tmc_wdata = MC_MAX;
                clr_next  = clr_reg + (ADDR_W+1)'(1);
                if (clr_reg == (ADDR_W+1)'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_chosen_next = '0;
                    res_status_next = STATUS_OK;
                    case (item.func)
                        FUNC_WRITE:
                        begin
                            cnt_we     = 1'b1;
                            state_next = ST_FIN;
                        end
                        FUNC_MODES:
                        begin
                            tmc_we     = 1'b1;
                            state_next = ST_FIN;
                        end
                        FUNC_BUILD:
                        begin
                            cur_tile_next = '0;
                            skip_next     = 1'b0;
                            state_next    = ST_BLD_TILE;
                        end
                        default:
                        begin
                            state_next = ST_SMP_RD;
                        end
                    endcase
                end
            end
            ST_SMP_RD:
            begin
                tmc_raddr  = item_reg.tile;
                tbl_raddr  = {item_reg.tile, item_reg.mode};
                state_next = ST_SMP_EV;
            end
            ST_SMP_EV:
            begin
                if ({1'b0, item_reg.mode} >= tmc_rdata)
                begin
                    res_status_next = STATUS_RANGE;
                end
                else if ({1'b0, item_reg.rand_fraction} < tbl_rdata[TBL_W-1:MODE_W])
                begin
                    res_chosen_next = item_reg.mode;
                end
                else
                begin
                    res_chosen_next = tbl_rdata[MODE_W-1:0];
                end
                state_next = ST_FIN;
            end
            ST_BLD_TILE:
            begin
                if (cur_tile_reg >= lim)
                begin
                    res_status_next = skip_reg ? STATUS_SKIP : STATUS_OK;
                    state_next      = ST_FIN;
                end
                else
                begin
                    state_next = ST_BLD_N;
                end
            end
            ST_BLD_N:
            begin
                n_next     = tmc_rdata;
                j_next     = '0;
                total_next = '0;
                state_next = ST_SUM_RD;
            end
            ST_SUM_RD:
            begin
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                total_next = sum_acc;
                if (j_reg + MC_W'(1) == n_reg)
                begin
                    j_next = '0;
                    if (sum_acc == '0)
                    begin
                        // zero total: keep old tables, flag the skip
                        skip_next     = 1'b1;
                        cur_tile_next = cur_tile_reg + TIU_W'(1);
                        state_next    = ST_BLD_TILE;
                    end
                    else
                    begin
                        ns_next    = '0;
                        nl_next    = '0;
                        state_next = ST_P_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + MC_W'(1);
                    state_next = ST_SUM_RD;
                end
            end
            ST_P_RD:
            begin
                state_next = ST_P_DIV;
            end
            ST_P_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_P_WAIT;
            end
            ST_P_WAIT:
            begin
                if (div_done)
                begin
                    wp_we = 1'b1;
                    if (div_q < ONE_FX)
                    begin
                        small_we = 1'b1;
                        ns_next  = ns_reg + MC_W'(1);
                    end
                    else
                    begin
                        large_we = 1'b1;
                        nl_next  = nl_reg + MC_W'(1);
                    end
                    j_next = j_reg + MC_W'(1);
                    if (j_reg + MC_W'(1) == n_reg)
                    begin
                        state_next = ST_PAIR_S;
                    end
                    else
                    begin
                        state_next = ST_P_RD;
                    end
                end
            end
            ST_PAIR_S:
            begin
                if (ns_reg == '0 || nl_reg == '0)
                begin
                    state_next = ST_LEFT_RD;
                end
                else
                begin
                    wp_ridx    = s_top;
                    ps_next    = wp_rd;
                    state_next = ST_PAIR_L;
                end
            end
            ST_PAIR_L:
            begin
                wp_ridx    = l_top;
                pl_next    = wp_rd;
                state_next = ST_PAIR_WR;
            end
            ST_PAIR_WR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = {cur_tile_reg[TILE_W-1:0], s_top};
                tbl_wdata = {ps_reg[PROB_W-1:0], l_top};
                wp_we     = 1'b1;
                wp_widx   = l_top;
                wp_wdata  = new_l;
                if (new_l < ONE_FX)
                begin
                    // large entry drops below 1.0: replace the popped small entry
                    small_we    = 1'b1;
                    small_widx  = ns_m1[MODE_W-1:0];
                    small_wdata = l_top;
                    nl_next     = nl_m1;
                end
                else
                begin
                    ns_next = ns_m1;
                end
                state_next = ST_PAIR_S;
            end
            ST_LEFT_RD:
            begin
                if (ns_reg == '0 && nl_reg == '0)
                begin
                    cur_tile_next = cur_tile_reg + TIU_W'(1);
                    state_next    = ST_BLD_TILE;
                end
                else
                begin
                    state_next = ST_LEFT_WR;
                end
            end
            ST_LEFT_WR:
            begin
                // leftover entry: prob 1.0, alias kept
                tbl_we = 1'b1;
                if (nl_reg != '0)
                begin
                    nl_next = nl_m1;
                end
                else
                begin
                    ns_next = ns_m1;
                end
                state_next = ST_LEFT_RD;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    result_next.chosen_mode = res_chosen_reg;
                    result_next.status      = res_status_reg;
                    result_valid_next       = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
            cur_tile_reg     <= '0;
            skip_reg         <= 1'b0;
            n_reg            <= '0;
            j_reg            <= '0;
            ns_reg           <= '0;
            nl_reg           <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            result_valid_reg <= result_valid_next;
            cur_tile_reg     <= cur_tile_next;
            skip_reg         <= skip_next;
            n_reg            <= n_next;
            j_reg            <= j_next;
            ns_reg           <= ns_next;
            nl_reg           <= nl_next;
        end
    end

    // payload and scratch: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        total_reg      <= total_next;
        ps_reg         <= ps_next;
        pl_reg         <= pl_next;
        res_chosen_reg <= res_chosen_next;
        res_status_reg <= res_status_next;
        result_reg     <= result_next;
        if (wp_we)
        begin
            wp_reg[wp_widx] <= wp_wdata;
        end
        if (small_we)
        begin
            small_reg[small_widx] <= small_wdata;
        end
        if (large_we)
        begin
            large_reg[large_widx] <= large_wdata;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/ats_ram.sv -----
module ats_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ats_div.sv -----
module ats_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ats_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [ats_pkg::TOTAL_W-1:0]   divisor,
    output logic                          done,
    output logic [ats_pkg::WP_W-1:0]      quotient
);
    import ats_pkg::*;

    localparam int STEPS = WP_W;
    localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [4:0]            step_reg, step_next;
    logic [TOTAL_W-1:0]    rem_reg, rem_next;
    logic [WP_W-1:0]       low_reg, low_next;
    logic [WP_W-1:0]       q_reg, q_next;
    logic [TOTAL_W-1:0]    div_reg, div_next;
    logic [TOTAL_W:0]      trial;
    logic                  fits;

    // one quotient bit per cycle; quotient is known to fit WP_W bits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        trial     = {rem_reg, low_reg[WP_W-1]};
        fits      = (trial >= {1'b0, div_reg});
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = TOTAL_W'(dividend[DIVIDEND_W-1:WP_W]);
            low_next  = dividend[WP_W-1:0];
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? TOTAL_W'(trial - {1'b0, div_reg}) : TOTAL_W'(trial);
            low_next = {low_reg[WP_W-2:0], 1'b0};
            q_next   = {q_reg[WP_W-2:0], fits};
            step_next = step_reg + 5'd1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/ats_checker.sv -----
module ats_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_stall,
    input logic             result_valid,
    input logic             result_stall,
    input ats_pkg::result_t result
);
    import ats_pkg::*;

    // hold a stalled word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_OK || result.status == STATUS_SKIP
                          || result.status == STATUS_RANGE))
        else $error("bad status code");

    a_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.chosen_mode != '0 |-> result.status == STATUS_OK)
        else $error("nonzero mode with error status");

    a_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> item_stall)
        else $error("item taken during clearing pass");

endmodule

bind alias_table_build_and_sample_top ats_checker u_ats_checker (
    .clk(clk),
    .rst_n(rst_n),
    .item_stall(item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import ats_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alias_table_build_and_sample_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Shadow copy of the block's state, kept in step with every accepted word.
    logic [COUNT_W-1:0] hist [STORE_DEPTH];
    logic [MC_W-1:0]    modes_of [MAX_TILES];
    logic [PROB_W-1:0]  prob_tbl [STORE_DEPTH];
    logic [MODE_W-1:0]  alias_tbl [STORE_DEPTH];
    logic [TIU_W-1:0]   tiles_live;

    result_t pending_results [$];
    int      err_count;
    int      cycle_count;
    int      snd_idle_pct;
    int      rcv_idle_pct;
    int      hold_left;
    int      n_samples, n_range, n_builds, n_skips, n_writes;

    // Vose construction for one tile; returns 0 when the tile's total is zero.
    function automatic bit rebuild_tile(input int t);
        int                n;
        int                base;
        longint unsigned   total;
        longint unsigned   wp [MAX_MODES];
        int                sm [MAX_MODES];
        int                lg [MAX_MODES];
        int                ns, nl, s, l;
        n     = modes_of[t];
        base  = t * MAX_MODES;
        total = 0;
        ns    = 0;
        nl    = 0;
        if (n < 1) n = 1;
        if (n > MAX_MODES) n = MAX_MODES;
        for (int j = 0; j < n; j++) total += hist[base + j];
        if (total == 0) return 1'b0;
        for (int j = 0; j < n; j++)
        begin
            wp[j] = (longint'(hist[base + j]) * n * (64'd1 << FRAC_W)) / total;
            if (wp[j] < (64'd1 << FRAC_W))
            begin
                sm[ns] = j;
                ns++;
            end
            else
            begin
                lg[nl] = j;
                nl++;
            end
        end
        while (ns > 0 && nl > 0)
        begin
            ns--;
            s = sm[ns];
            l = lg[nl - 1];
            prob_tbl[base + s]  = PROB_W'(wp[s]);
            alias_tbl[base + s] = MODE_W'(l);
            wp[l] = wp[l] + wp[s] - (64'd1 << FRAC_W);
            if (wp[l] < (64'd1 << FRAC_W))
            begin
                sm[ns] = l;
                ns++;
                nl--;
            end
        end
        // leftovers on either stack become certain picks, alias untouched
        while (nl > 0)
        begin
            nl--;
            prob_tbl[base + lg[nl]] = ONE_PROB;
        end
        while (ns > 0)
        begin
            ns--;
            prob_tbl[base + sm[ns]] = ONE_PROB;
        end
        return 1'b1;
    endfunction

    // Apply one word to the shadow state and return the result word it owes.
    function automatic result_t predict_word(input item_t w);
        result_t r;
        int      lim;
        int      a;
        logic [MC_W-1:0] mc;
        r = '0;
        r.status = STATUS_OK;
        case (w.func)
            FUNC_WRITE:
            begin
                hist[{w.tile, w.mode}] = w.count;
                n_writes++;
            end
            FUNC_MODES:
            begin
                mc = w.mode_count;
                if (mc < MC_W'(1)) mc = MC_W'(1);
                if (mc > MC_MAX) mc = MC_MAX;
                modes_of[w.tile] = mc;
            end
            FUNC_BUILD:
            begin
                lim = tiles_live;
                if (lim > MAX_TILES) lim = MAX_TILES;
                for (int t = 0; t < lim; t++)
                    if (!rebuild_tile(t)) r.status = STATUS_SKIP;
                n_builds++;
                if (r.status == STATUS_SKIP) n_skips++;
            end
            default:
            begin
                n_samples++;
                if (w.mode >= modes_of[w.tile])
                begin
                    r.status = STATUS_RANGE;
                    n_range++;
                end
                else
                begin
                    a = int'({w.tile, w.mode});
                    r.chosen_mode = ({1'b0, w.rand_fraction} < prob_tbl[a]) ?
                                    w.mode : alias_tbl[a];
                end
            end
        endcase
        return r;
    endfunction

    // Clock: 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: abort a hung run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t timeout after %0d cycles, %0d words outstanding",
                         $time, cycle_count, pending_results.size());
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Receiver stall: random per phase, plus a long hold-off on request.
    initial
    begin
        result_stall = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall = ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    // Result checker: compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result word: chosen_mode=%0d status=%0d",
                         $time, result.chosen_mode, result.status);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.chosen_mode !== want.chosen_mode)
                begin
                    $display("%0t chosen_mode mismatch: expected %0d actual %0d",
                             $time, want.chosen_mode, result.chosen_mode);
                    err_count++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.status, result.status);
                    err_count++;
                end
            end
        end
    end

    // Offer one word, wait for the handshake, queue its expected result.
    // Valid stays high on return; call drop_valid before any pause.
    task automatic send_word(input item_t w, input bit typed, input result_t want);
        result_t r;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item       = w;
        item_valid = 1'b1;
        do @(posedge clk); while (item_stall);
        r = predict_word(w);
        pending_results.insert(pending_results.size(), typed ? want : r);
        @(negedge clk);
    endtask

    task automatic drop_valid();
        item_valid = 1'b0;
    endtask

    // Wait for every outstanding result, then let the block settle.
    task automatic drain();
        drop_valid();
        while (pending_results.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic set_tiles_in_use(input logic [TIU_W-1:0] v);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_TILES_IN_USE;
        pwdata  = 32'(v);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        tiles_live = v;
    endtask

    function automatic item_t mk(input logic [1:0] f, input int t, input int m,
                                 input int c, input int mc, input int fr);
        item_t w;
        w.func          = f;
        w.tile          = TILE_W'(t);
        w.mode          = MODE_W'(m);
        w.count         = COUNT_W'(c);
        w.mode_count    = MC_W'(mc);
        w.rand_fraction = FRAC_W'(fr);
        return w;
    endfunction

    // Random word: mostly aimed at a few hot tiles so builds see real histograms.
    function automatic item_t random_word(input int build_pct);
        item_t w;
        int    k;
        int    hot;
        w   = item_t'({$urandom, $urandom});
        k   = $urandom_range(0, 99);
        hot = (tiles_live >= 8 || tiles_live == 0) ? 7 : tiles_live - 1;
        if (k < build_pct)            w.func = FUNC_BUILD;
        else if (k < build_pct + 40)  w.func = FUNC_WRITE;
        else if (k < build_pct + 50)  w.func = FUNC_MODES;
        else                          w.func = FUNC_SAMPLE;
        if ($urandom_range(0, 9) != 0) w.tile = TILE_W'($urandom_range(0, hot));
        k = $urandom_range(0, 9);
        if (k < 2)       w.count = '0;
        else if (k == 2) w.count = '1;
        if ($urandom_range(0, 1) != 0) w.mode_count = MC_W'($urandom_range(1, 6));
        return w;
    endfunction

    typedef struct {
        item_t   w;
        bit      typed;
        result_t want;
    } stim_row_t;

    stim_row_t directed [$];

    task automatic add_row(input item_t w, input bit typed,
                           input logic [MODE_W-1:0] cm, input logic [1:0] st);
        stim_row_t row;
        row.w                = w;
        row.typed            = typed;
        row.want.chosen_mode = cm;
        row.want.status      = st;
        directed.insert(directed.size(), row);
    endtask

    initial
    begin
        logic [TIU_W-1:0] tiu_plan [6];
        int               bpct;
        item_t            w;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_left    = 0;
        err_count    = 0;
        n_samples    = 0;
        n_range      = 0;
        n_builds     = 0;
        n_skips      = 0;
        n_writes     = 0;
        snd_idle_pct = 33;
        rcv_idle_pct = 70;
        tiles_live   = TIU_RESET;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            hist[i]      = '0;
            prob_tbl[i]  = ONE_PROB;
            alias_tbl[i] = '0;
        end
        for (int i = 0; i < MAX_TILES; i++) modes_of[i] = MC_MAX;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table; typed expectations where the answer is obvious.
        // Fresh tables hold 1.0, so any fraction keeps the index.
        add_row(mk(FUNC_SAMPLE, 0, 0, 0, 0, 16'hFFFF), 1, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 63, 15, 0, 0, 16'hFFFF), 1, 15, STATUS_OK);
        // empty histograms: every tile skipped
        add_row(mk(FUNC_BUILD, 0, 0, 0, 0, 0), 1, 0, STATUS_SKIP);
        add_row(mk(FUNC_WRITE, 0, 0, 16'hFFFF, 0, 0), 1, 0, STATUS_OK);
        add_row(mk(FUNC_WRITE, 0, 15, 1, 0, 0), 1, 0, STATUS_OK);
        add_row(mk(FUNC_WRITE, 63, 15, 16'hFFFF, 31, 16'hFFFF), 1, 0, STATUS_OK);
        // mode count zero clamps to one, oversize clamps to sixteen
        add_row(mk(FUNC_MODES, 1, 0, 0, 0, 0), 1, 0, STATUS_OK);
        add_row(mk(FUNC_MODES, 2, 0, 0, 31, 0), 1, 0, STATUS_OK);
        add_row(mk(FUNC_MODES, 63, 0, 0, 17, 0), 1, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 1, 1, 0, 0, 0), 1, 0, STATUS_RANGE);
        add_row(mk(FUNC_SAMPLE, 1, 0, 0, 0, 0), 1, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 2, 15, 0, 0, 16'hFFFF), 1, 15, STATUS_OK);
        add_row(mk(FUNC_MODES, 3, 0, 0, 2, 0), 1, 0, STATUS_OK);
        add_row(mk(FUNC_WRITE, 3, 0, 3, 0, 0), 1, 0, STATUS_OK);
        add_row(mk(FUNC_WRITE, 3, 1, 1, 0, 0), 1, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 3, 2, 0, 0, 0), 1, 0, STATUS_RANGE);
        add_row(mk(FUNC_BUILD, 0, 0, 0, 0, 0), 0, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 3, 1, 0, 0, 0), 0, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 3, 1, 0, 0, 16'hFFFF), 0, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 3, 0, 0, 0, 16'hFFFF), 0, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 0, 15, 0, 0, 16'hFFFF), 0, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 0, 0, 0, 0, 16'h0000), 0, 0, STATUS_OK);
        add_row(mk(FUNC_SAMPLE, 63, 15, 0, 0, 16'h8000), 0, 0, STATUS_OK);
        foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].want);
        drain();

        // Random phases, each under its own tile count; zero and oversize included.
        tiu_plan[0] = 7'd1;
        tiu_plan[1] = 7'd0;
        tiu_plan[2] = 7'd127;
        tiu_plan[3] = 7'd8;
        tiu_plan[4] = 7'd3;
        tiu_plan[5] = TIU_W'($urandom_range(1, 64));
        for (int ph = 0; ph < 6; ph++)
        begin
            // receiver-heavy gaps, then sender-heavy, then none
            case (ph / 2)
                0:       begin snd_idle_pct = 33; rcv_idle_pct = 70; end
                1:       begin snd_idle_pct = 70; rcv_idle_pct = 33; end
                default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
            endcase
            set_tiles_in_use(tiu_plan[ph]);
            // Builds over 16 or more tiles run one divide per mode of every tile; keep them rare.
            bpct = (tiles_live >= 16) ? 1 : 6;
            // Hold the receiver off while words keep coming so the input backs up.
            if (ph == 1 || ph == 4)
            begin
                @(posedge clk);
                hold_left = 300;
                @(negedge clk);
            end
            for (int n = 0; n < 100; n++)
            begin
                w = random_word(bpct);
                send_word(w, 0, '0);
                // pause the sender mid-phase until the block runs dry
                if (n == 50 && ph == 3) drain();
            end
            drain();
        end

        repeat (50) @(negedge clk);
        $display("covered %0d samples (%0d out of range), %0d count writes,",
                 n_samples, n_range, n_writes);
        $display("and %0d builds (%0d with skipped tiles) over six tile-count settings",
                 n_builds, n_skips);
        if (err_count == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
